// ===== rtl/rcw_pkg.sv =====
// ----------------------------------------------------------------------------
// rcw_pkg
// Shared types and constants for the recursive contribution weighting block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcw_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned EPS_W   = 31;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TLEN_W  = 13;
  localparam int unsigned CADDR_W = 2;

  localparam logic [CADDR_W-1:0] REG_REGULARIZATION = 2'd0;
  localparam logic [CADDR_W-1:0] REG_INITIAL_WEIGHT = 2'd1;
  localparam logic [CADDR_W-1:0] REG_TRACE_LENGTH   = 2'd2;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_PROCESS = 1'b1;

  localparam logic [TLEN_W-1:0] TRACE_LENGTH_RST   = 13'd4096;
  localparam logic [EPS_W-1:0]  REGULARIZATION_RST = 31'd65536;

  typedef struct packed {
    logic signed [DATA_W-1:0] gather;
    logic signed [DATA_W-1:0] stack;
    logic                     first;
    logic                     last;
  } rcw_item_t;

endpackage

`default_nettype wire

// ===== rtl/rcw_front.sv =====
// ----------------------------------------------------------------------------
// rcw_front
// Accepts requests, stores stack samples and looks up the stack sample that
// goes with each gather sample before handing it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_front #(
  parameter int unsigned MAX_SAMPLES = rcw_pkg::MAX_SAMPLES_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [rcw_pkg::DATA_W-1:0]    in_tdata,
  input  wire logic                          in_tuser,
  input  wire logic [rcw_pkg::TLEN_W-1:0]    trace_length,
  output logic                               push,
  output rcw_pkg::rcw_item_t                 push_item,
  input  wire logic                          push_ready
);

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic [31:0] len32;
  logic [31:0] ld32, sp32, ld_eff, sp_eff;
  logic        accept;
  logic        is_load;

  logic [AW-1:0]               ld_pos_r, ld_pos_nxt;
  logic [AW-1:0]               sp_pos_r, sp_pos_nxt;
  logic                        st_v_r, st_v_nxt;
  logic [rcw_pkg::DATA_W-1:0]  st_g_r;
  logic                        st_first_r, st_last_r;
  logic [rcw_pkg::DATA_W-1:0]  rd_r;
  logic [rcw_pkg::DATA_W-1:0]  mem [MAX_SAMPLES];

  always_comb begin
    if (trace_length == '0) begin
      len32 = 32'd1;
    end else if (32'(trace_length) > 32'(MAX_SAMPLES)) begin
      len32 = 32'(MAX_SAMPLES);
    end else begin
      len32 = 32'(trace_length);
    end
    ld32   = 32'(ld_pos_r);
    sp32   = 32'(sp_pos_r);
    ld_eff = (ld32 >= len32) ? len32 - 32'd1 : ld32;
    sp_eff = (sp32 >= len32) ? len32 - 32'd1 : sp32;
  end

  assign push      = st_v_r;
  assign in_tready = !st_v_r || push_ready;
  assign accept    = in_tvalid && in_tready;
  assign is_load   = (in_tuser == rcw_pkg::REQ_LOAD);

  assign push_item.gather = st_g_r;
  assign push_item.stack  = rd_r;
  assign push_item.first  = st_first_r;
  assign push_item.last   = st_last_r;

  always_comb begin
    ld_pos_nxt = ld_pos_r;
    sp_pos_nxt = sp_pos_r;
    st_v_nxt   = st_v_r && !push_ready;
    if (accept && is_load) begin
      ld_pos_nxt = (ld_eff == len32 - 32'd1) ? '0 : AW'(ld_eff + 32'd1);
    end
    if (accept && !is_load) begin
      sp_pos_nxt = (sp_eff == len32 - 32'd1) ? '0 : AW'(sp_eff + 32'd1);
      st_v_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_pos_r <= '0;
      sp_pos_r <= '0;
      st_v_r   <= 1'b0;
    end else begin
      ld_pos_r <= ld_pos_nxt;
      sp_pos_r <= sp_pos_nxt;
      st_v_r   <= st_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_load) begin
      mem[ld_eff[AW-1:0]] <= in_tdata;
    end
    if (accept && !is_load) begin
      rd_r       <= mem[sp_eff[AW-1:0]];
      st_g_r     <= in_tdata;
      st_first_r <= (sp_eff == 32'd0);
      st_last_r  <= (sp_eff == len32 - 32'd1);
    end
  end

  st_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    st_v_r && !push_ready |=> st_v_r && $stable(st_g_r))
    else $error("front stage lost an item");

  st_first_last: assert property (@(posedge clk) disable iff (!rst_n)
    st_v_r && st_first_r && (trace_length > 13'd1) && (32'(trace_length) <= 32'(MAX_SAMPLES))
      |-> !st_last_r || !$stable(trace_length))
    else $error("first sample flagged last");

  ld_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_load |=> (32'(ld_pos_r) < 32'(MAX_SAMPLES)))
    else $error("load position out of range");

endmodule

`default_nettype wire

// ===== rtl/rcw_queue.sv =====
// ----------------------------------------------------------------------------
// rcw_queue
// Short FIFO between the request front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_queue (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire logic                 push,
  input  wire rcw_pkg::rcw_item_t   push_item,
  output logic                      push_ready,
  input  wire logic                 pop,
  output logic                      pop_valid,
  output rcw_pkg::rcw_item_t        pop_item
);

  localparam int unsigned D  = rcw_pkg::QUEUE_DEPTH;
  localparam int unsigned PW = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned CW = $clog2(D + 1);

  rcw_pkg::rcw_item_t buf_r [D];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != CW'(D));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = buf_r[rp_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (32'(wp_r) == D - 1) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (32'(rp_r) == D - 1) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wp_r] <= push_item;
    end
  end

  q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= D)
    else $error("queue count overflow");

  q_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) || (cnt_r == CW'(D)) |-> wp_r == rp_r)
    else $error("queue pointers disagree with count");

  q_grow: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("queue count did not grow");

endmodule

`default_nettype wire

// ===== rtl/rcw_back.sv =====
// ----------------------------------------------------------------------------
// rcw_back
// Weight update engine: shared multiplier, wide sums, radix-2 restoring
// divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_back (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire logic [rcw_pkg::EPS_W-1:0]     regularization,
  input  wire logic [rcw_pkg::DATA_W-1:0]    initial_weight,
  input  wire logic                          pop_valid,
  input  wire rcw_pkg::rcw_item_t            pop_item,
  output logic                               pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [2*rcw_pkg::DATA_W-1:0]       out_tdata,
  output logic                               out_tlast
);

  typedef enum logic [3:0] {
    S_IDLE, S_MGS, S_MGG, S_MPP, S_MLO, S_MHI, S_SUMB, S_SUMN,
    S_ABS, S_DIV, S_QSAT, S_MGW, S_OUT
  } state_t;

  state_t state_r;

  logic signed [31:0] g_r, s_r, w0_r, w_r, ws_r, run_r;
  logic               last_r, neg_r;
  logic [63:0]        gs_r, gg_r, den_r, rem_r;
  logic [61:0]        pp_r;
  logic [62:0]        lo_r, hi_r;
  logic [93:0]        bm_r;
  logic [95:0]        dv_r;
  logic [34:0]        q_r;
  logic [6:0]         cnt_r;
  logic               out_v_r, out_last_r;
  logic [31:0]        out_w_r, out_ws_r;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic [31:0]        aw;
  logic [95:0]        a96, b96, num;
  logic [63:0]        remsh;
  logic               qb;
  logic [34:0]        qs;
  logic signed [63:0] p64, sh64;

  assign aw   = w0_r[31] ? 32'(-w0_r) : 32'(w0_r);
  assign prod = ma * mb;
  assign pop  = (state_r == S_IDLE) && pop_valid;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_MGS: begin
        ma = 33'(g_r);
        mb = 33'(s_r);
      end
      S_MGG: begin
        ma = 33'(g_r);
        mb = 33'(g_r);
      end
      S_MPP: begin
        ma = {2'b0, regularization};
        mb = {2'b0, regularization};
      end
      S_MLO: begin
        ma = {2'b0, pp_r[30:0]};
        mb = {1'b0, aw};
      end
      S_MHI: begin
        ma = {2'b0, pp_r[61:31]};
        mb = {1'b0, aw};
      end
      S_MGW: begin
        ma = 33'(g_r);
        mb = 33'(w_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    a96   = {{16{gs_r[63]}}, gs_r, 16'b0};
    b96   = {2'b0, bm_r};
    num   = a96 + (w0_r[31] ? ~b96 : b96) + 96'(w0_r[31]);
    remsh = {rem_r[62:0], dv_r[95]};
    qb    = (remsh >= den_r);
    qs    = {q_r[33:0], qb};
    if (qs > 35'h200000000) begin
      qs = 35'h200000000;
    end
    p64  = prod[63:0];
    sh64 = p64 >>> 16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      run_r   <= '0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            g_r     <= pop_item.gather;
            s_r     <= pop_item.stack;
            last_r  <= pop_item.last;
            w0_r    <= pop_item.first ? initial_weight : run_r;
            state_r <= S_MGS;
          end
        end
        S_MGS: begin
          gs_r    <= prod[63:0];
          state_r <= S_MGG;
        end
        S_MGG: begin
          gg_r    <= prod[63:0];
          state_r <= S_MPP;
        end
        S_MPP: begin
          pp_r    <= prod[61:0];
          state_r <= S_MLO;
        end
        S_MLO: begin
          lo_r    <= prod[62:0];
          state_r <= S_MHI;
        end
        S_MHI: begin
          hi_r    <= prod[62:0];
          state_r <= S_SUMB;
        end
        S_SUMB: begin
          bm_r    <= {31'b0, lo_r} + {hi_r, 31'b0};
          den_r   <= gg_r + {2'b0, pp_r};
          state_r <= S_SUMN;
        end
        S_SUMN: begin
          neg_r   <= num[95];
          dv_r    <= num;
          state_r <= S_ABS;
        end
        S_ABS: begin
          if (neg_r) begin
            dv_r <= -dv_r;
          end
          rem_r <= '0;
          q_r   <= '0;
          cnt_r <= '0;
          if (den_r == '0) begin
            w_r     <= w0_r;
            state_r <= S_MGW;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= qb ? remsh - den_r : remsh;
          q_r   <= qs;
          dv_r  <= {dv_r[94:0], 1'b0};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd95) begin
            state_r <= S_QSAT;
          end
        end
        S_QSAT: begin
          if (neg_r) begin
            w_r <= (q_r > 35'h080000000) ? 32'sh80000000 : -$signed(q_r[31:0]);
          end else begin
            w_r <= (q_r > 35'h07fffffff) ? 32'sh7fffffff : $signed(q_r[31:0]);
          end
          state_r <= S_MGW;
        end
        S_MGW: begin
          if (sh64 > 64'sh7fffffff) begin
            ws_r <= 32'sh7fffffff;
          end else if (sh64 < -64'sh80000000) begin
            ws_r <= 32'sh80000000;
          end else begin
            ws_r <= sh64[31:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_v_r || out_tready) begin
            out_v_r    <= 1'b1;
            out_w_r    <= w_r;
            out_ws_r   <= ws_r;
            out_last_r <= last_r;
            run_r      <= w_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (out_v_r && out_tready && !(state_r == S_OUT)) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_ws_r, out_w_r};
  assign out_tlast  = out_last_r;

  div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

  pop_start: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == S_MGS)
    else $error("popped item not started");

  out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(state_r) == S_OUT)
    else $error("result shown without finishing an item");

  div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_QSAT |-> $past(cnt_r) == 7'd95)
    else $error("division ended early");

endmodule

`default_nettype wire

// ===== rtl/recursive_contribution_weighting_top.sv =====
// ----------------------------------------------------------------------------
// recursive_contribution_weighting_top
// Recursive contribution weighting: running Q16.16 weight per gather sample.
// ----------------------------------------------------------------------------
// Load requests (tuser 0) store the next stack sample. Process requests
// (tuser 1) produce one result; the back end handles one item at a time,
// using the 96-step radix-2 divider (skipped when the denominator is zero)
// and six passes through the shared 33x33 multiplier. Loads keep flowing into
// the stack memory while the back end works, until the two-entry queue and the front stage are full.
`default_nettype none

module recursive_contribution_weighting_top #(
  parameter int unsigned MAX_SAMPLES = rcw_pkg::MAX_SAMPLES_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rcw_pkg::CADDR_W-1:0]    cfg_addr,
  input  wire logic [rcw_pkg::DATA_W-1:0]     cfg_wdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [rcw_pkg::DATA_W-1:0]     in_tdata,   // sample_value
  input  wire logic                           in_tuser,   // req_type
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [2*rcw_pkg::DATA_W-1:0]        out_tdata,  // weight_value, weighted_sample
  output logic                                out_tlast
);

  logic [rcw_pkg::EPS_W-1:0]  eps_r;
  logic [rcw_pkg::DATA_W-1:0] init_r;
  logic [rcw_pkg::TLEN_W-1:0] tlen_r;

  logic               push, push_ready, pop, pop_valid;
  rcw_pkg::rcw_item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= rcw_pkg::REGULARIZATION_RST;
      init_r <= '0;
      tlen_r <= rcw_pkg::TRACE_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        rcw_pkg::REG_REGULARIZATION: eps_r  <= cfg_wdata[rcw_pkg::EPS_W-1:0];
        rcw_pkg::REG_INITIAL_WEIGHT: init_r <= cfg_wdata;
        rcw_pkg::REG_TRACE_LENGTH:   tlen_r <= cfg_wdata[rcw_pkg::TLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rcw_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .trace_length (tlen_r),
    .push         (push),
    .push_item    (push_item),
    .push_ready   (push_ready)
  );

  rcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  rcw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .regularization (eps_r),
    .initial_weight (init_r),
    .pop_valid      (pop_valid),
    .pop_item       (pop_item),
    .pop            (pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast)
  );

endmodule

`default_nettype wire
